// ===== rtl/imm_pkg.sv =====
package imm_pkg;

    // Default largest matrix dimension held in the stores.
    localparam int MAX_DIM_DEF = 16;

    // Item commands.
    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_MUL  = 2'd2,
        CMD_RD_C = 2'd3
    } t_cmd;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_RIGHT_COLS = 2'd2;

    // Configuration reset value.
    localparam logic [4:0] CFG_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_READ,
        ST_ACK
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] data;
        logic               out_of_range;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_a;
        logic write_b;
        logic read_c;
        logic issue;
        logic first;
        logic last;
        logic zero;
        logic load_read;
        logic load_ack;
    } t_dp_cmd;

endpackage

// ===== rtl/imm_datapath.sv =====
module imm_datapath #(
    parameter int MAX_DIM = 16,
    parameter int IX_W    = 4,
    parameter int CNT_W   = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  imm_pkg::t_dp_cmd i_cmd,
    input  imm_pkg::t_in     i_in,
    input  logic [IX_W-1:0]  i_i,
    input  logic [IX_W-1:0]  i_j,
    input  logic [IX_W-1:0]  i_k,
    input  logic [CNT_W-1:0] i_eff_rows,
    input  logic [CNT_W-1:0] i_eff_cols,
    input  logic [CNT_W-1:0] i_c_rows,
    input  logic [CNT_W-1:0] i_c_cols,
    output logic             o_busy,
    output imm_pkg::t_out    o_out
);
    import imm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] r_mem_a [DEPTH];
    logic [31:0] r_mem_b [DEPTH];
    logic [31:0] r_mem_c [DEPTH];

    logic              in_store;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] ij_addr;

    // Stage registers of the multiply-accumulate pipeline.
    logic              r_s1_valid, r_s1_first, r_s1_last, r_s1_zero;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [31:0]       r_s1_a, r_s1_b;
    logic              r_s2_valid, r_s2_first, r_s2_last, r_s2_zero;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [31:0]       r_s2_prod;
    logic [31:0]       r_acc;
    logic [31:0]       n_acc;

    // Read path registers.
    logic [31:0] r_rd_data;
    logic        r_rd_oor;
    logic        r_rd_zero;
    t_out        r_out;

    // Element addresses in row-major order.
    assign in_store = (32'(i_in.row) < MAX_DIM) && (32'(i_in.col) < MAX_DIM);
    assign in_addr  = in_store ? ADDR_W'(32'(i_in.row) * MAX_DIM + 32'(i_in.col)) : '0;
    assign a_addr   = ADDR_W'(32'(i_i) * MAX_DIM + 32'(i_k));
    assign b_addr   = ADDR_W'(32'(i_k) * MAX_DIM + 32'(i_j));
    assign ij_addr  = ADDR_W'(32'(i_i) * MAX_DIM + 32'(i_j));

    // Operand stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_a && in_store) begin
            r_mem_a[in_addr] <= i_in.value;
        end
        if (i_cmd.write_b && in_store) begin
            r_mem_b[in_addr] <= i_in.value;
        end
        r_s1_a <= r_mem_a[a_addr];
        r_s1_b <= r_mem_b[b_addr];
    end

    // Pipeline tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_zero  <= i_cmd.zero;
        r_s1_addr  <= ij_addr;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_zero  <= r_s1_zero;
        r_s2_addr  <= r_s1_addr;
        r_s2_prod  <= 32'(r_s1_a * r_s1_b);
    end

    // Accumulate, restarting at the first term of each dot product.
    always_comb begin
        n_acc = (r_s2_first ? 32'd0 : r_acc) + (r_s2_zero ? 32'd0 : r_s2_prod);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
    end

    // Product store: written at the last term, read for read commands.
    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2_last) begin
            r_mem_c[r_s2_addr] <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_c) begin
            r_rd_data <= r_mem_c[in_addr];
            r_rd_oor  <= !((32'(i_in.row) < 32'(i_eff_rows)) &&
                           (32'(i_in.col) < 32'(i_eff_cols)));
            r_rd_zero <= !((32'(i_in.row) < 32'(i_c_rows)) &&
                           (32'(i_in.col) < 32'(i_c_cols)));
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack) begin
            r_out.kind         <= KIND_ACK;
            r_out.data         <= '0;
            r_out.out_of_range <= 1'b0;
        end else if (i_cmd.load_read) begin
            r_out.kind         <= KIND_READ;
            r_out.data         <= (r_rd_oor || r_rd_zero) ? 32'd0 : r_rd_data;
            r_out.out_of_range <= r_rd_oor;
        end
    end

    assign o_busy = r_s1_valid || r_s2_valid;
    assign o_out  = r_out;

endmodule

// ===== rtl/imm_ctrl.sv =====
module imm_ctrl #(
    parameter int MAX_DIM = 16,
    parameter int IX_W    = 4,
    parameter int CNT_W   = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_command,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [4:0]       i_cfg_data,
    input  logic             i_busy,
    output imm_pkg::t_dp_cmd o_cmd,
    output logic [IX_W-1:0]  o_i,
    output logic [IX_W-1:0]  o_j,
    output logic [IX_W-1:0]  o_k,
    output logic [CNT_W-1:0] o_eff_rows,
    output logic [CNT_W-1:0] o_eff_cols,
    output logic [CNT_W-1:0] o_c_rows,
    output logic [CNT_W-1:0] o_c_cols
);
    import imm_pkg::*;

    t_state           r_state, n_state;
    logic [4:0]       r_cfg_rows, r_cfg_inner, r_cfg_cols;
    logic [CNT_W-1:0] r_c_rows, r_c_cols;
    logic [IX_W-1:0]  r_i, r_j, r_k;
    logic             r_out_valid;
    logic [CNT_W-1:0] eff_rows, eff_inner, eff_cols;
    logic             accept;
    logic             k_last, j_last, i_last;

    // Sizes capped at the store dimension.
    assign eff_rows  = (32'(r_cfg_rows) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_cfg_rows);
    assign eff_inner = (32'(r_cfg_inner) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_cfg_inner);
    assign eff_cols  = (32'(r_cfg_cols) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_cfg_cols);

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign k_last = (eff_inner == '0) || (CNT_W'(r_k) + CNT_W'(1) == eff_inner);
    assign j_last = (CNT_W'(r_j) + CNT_W'(1) == r_c_cols);
    assign i_last = (CNT_W'(r_i) + CNT_W'(1) == r_c_rows);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows  <= CFG_RESET;
            r_cfg_inner <= CFG_RESET;
            r_cfg_cols  <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEFT_ROWS:  r_cfg_rows  <= i_cfg_data;
                CFG_INNER_SIZE: r_cfg_inner <= i_cfg_data;
                CFG_RIGHT_COLS: r_cfg_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_MUL) begin
                        n_state = (eff_rows == '0 || eff_cols == '0) ? ST_ACK : ST_MUL;
                    end else if (i_command == CMD_RD_C) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_MUL: begin
                if (k_last && j_last && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_busy) begin
                    n_state = ST_ACK;
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_ACK:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_c_rows    <= '0;
            r_c_cols    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_command == CMD_MUL) begin
                r_c_rows <= eff_rows;
                r_c_cols <= eff_cols;
            end
            if (r_state == ST_READ || r_state == ST_ACK) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Loop counters: k innermost, then column, then row.
    always_ff @(posedge i_clk) begin
        if (accept && i_command == CMD_MUL) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (r_state == ST_MUL) begin
            if (!k_last) begin
                r_k <= r_k + IX_W'(1);
            end else begin
                r_k <= '0;
                if (!j_last) begin
                    r_j <= r_j + IX_W'(1);
                end else begin
                    r_j <= '0;
                    r_i <= r_i + IX_W'(1);
                end
            end
        end
    end

    // Datapath commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.write_a   = accept && (i_command == CMD_WR_A);
        o_cmd.write_b   = accept && (i_command == CMD_WR_B);
        o_cmd.read_c    = accept && (i_command == CMD_RD_C);
        o_cmd.issue     = (r_state == ST_MUL);
        o_cmd.first     = (r_k == '0);
        o_cmd.last      = k_last;
        o_cmd.zero      = (eff_inner == '0);
        o_cmd.load_read = (r_state == ST_READ);
        o_cmd.load_ack  = (r_state == ST_ACK);
    end

    assign o_out_valid = r_out_valid;
    assign o_i         = r_i;
    assign o_j         = r_j;
    assign o_k         = r_k;
    assign o_eff_rows  = eff_rows;
    assign o_eff_cols  = eff_cols;
    assign o_c_rows    = r_c_rows;
    assign o_c_cols    = r_c_cols;

endmodule

// ===== rtl/int32_matrix_multiply.sv =====
// Signed 32-bit matrix product C = A*B, wrapping modulo 2^32. Each input word
// writes one element of A or B, starts the multiply, or reads one element of C;
// sizes come from three configuration registers (left_rows, inner_size,
// right_cols, capped at MAX_DIM). Element writes are accepted back to back while
// no result word waits on the receiver. A read passes its element through the
// read registers and then the output word register; indexes outside the
// configured size read 0 with out_of_range set. A multiply of nonzero size walks
// one multiply-accumulate pipeline fed by one read port per operand store, one
// term per cycle, and then returns an acknowledgement word. The product store
// needs no clearing pass: entries outside the last multiply's size read as zero.
module int32_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  imm_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output imm_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [4:0]    i_cfg_data
);
    import imm_pkg::*;

    localparam int IX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    t_dp_cmd          dp_cmd;
    logic             busy;
    logic [IX_W-1:0]  idx_i, idx_j, idx_k;
    logic [CNT_W-1:0] eff_rows, eff_cols, c_rows, c_cols;

    assign o_cfg_ready = 1'b1;

    imm_ctrl #(
        .MAX_DIM(MAX_DIM),
        .IX_W   (IX_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_in.command),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_busy     (busy),
        .o_cmd      (dp_cmd),
        .o_i        (idx_i),
        .o_j        (idx_j),
        .o_k        (idx_k),
        .o_eff_rows (eff_rows),
        .o_eff_cols (eff_cols),
        .o_c_rows   (c_rows),
        .o_c_cols   (c_cols)
    );

    imm_datapath #(
        .MAX_DIM(MAX_DIM),
        .IX_W   (IX_W),
        .CNT_W  (CNT_W)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_in      (i_in),
        .i_i       (idx_i),
        .i_j       (idx_j),
        .i_k       (idx_k),
        .i_eff_rows(eff_rows),
        .i_eff_cols(eff_cols),
        .i_c_rows  (c_rows),
        .i_c_cols  (c_cols),
        .o_busy    (busy),
        .o_out     (o_out)
    );

endmodule

// ===== tb/int32_matrix_multiply_test.sv =====
module int32_matrix_multiply_test;
    import imm_pkg::*;

    localparam int DIM = MAX_DIM_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int NUM_PHASES = 12;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    t_in          in_word;
    logic         out_valid;
    logic         out_ready;
    t_out         out_word;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [4:0]   cfg_data;

    int32_matrix_multiply dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock with a period of 10.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be sent and results waiting to be seen.
    t_in  pending_words[$];
    t_out expected_results[$];

    // Predicted block state.
    logic [31:0] left_mat[DIM][DIM];
    logic [31:0] right_mat[DIM][DIM];
    logic [31:0] product_mat[DIM][DIM];
    logic [4:0]  rows_reg;
    logic [4:0]  inner_reg;
    logic [4:0]  cols_reg;

    // Elements written so far, tracked while the stimulus is built.
    bit left_set[DIM][DIM];
    bit right_set[DIM][DIM];
    logic [4:0] gen_rows;
    logic [4:0] gen_inner;
    logic [4:0] gen_cols;

    int send_idle;
    int recv_idle;
    bit recv_hold;
    int phase_num;
    int mismatches;
    int results_seen;
    int words_sent;
    int multiplies_seen;
    int cycle_count;

    function automatic int capped(input logic [4:0] v);
        return (v > DIM) ? DIM : int'(v);
    endfunction

    // Clear the product, then form every dot product in 32-bit wrapping arithmetic.
    function automatic void compute_product();
        int rn;
        int kn;
        int cn;
        logic [31:0] acc;
        rn = capped(rows_reg);
        kn = capped(inner_reg);
        cn = capped(cols_reg);
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
                product_mat[i][j] = '0;
        for (int i = 0; i < rn; i++) begin
            for (int j = 0; j < cn; j++) begin
                acc = '0;
                for (int k = 0; k < kn; k++)
                    acc = acc + left_mat[i][k] * right_mat[k][j];
                product_mat[i][j] = acc;
            end
        end
    endfunction

    // Apply one accepted word to the predicted state and queue its result.
    function automatic void apply_word(input t_in w);
        t_out r;
        case (t_cmd'(w.command))
            CMD_WR_A: left_mat[w.row][w.col] = w.value;
            CMD_WR_B: right_mat[w.row][w.col] = w.value;
            CMD_MUL: begin
                compute_product();
                r.kind = KIND_ACK;
                r.data = '0;
                r.out_of_range = 1'b0;
                expected_results.push_back(r);
                multiplies_seen++;
            end
            default: begin
                r.kind = KIND_READ;
                if (w.row < capped(rows_reg) && w.col < capped(cols_reg)) begin
                    r.data = product_mat[w.row][w.col];
                    r.out_of_range = 1'b0;
                end else begin
                    r.data = '0;
                    r.out_of_range = 1'b1;
                end
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // Driver: offers the next pending word, holding it until it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                apply_word(in_word);
                words_sent++;
            end
            if (!in_valid || in_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_out e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word: kind %0d data %0d flag %0d",
                                 out_word.kind, out_word.data, out_word.out_of_range);
                end else begin
                    e = expected_results.pop_front();
                    if (out_word.kind !== e.kind || out_word.data !== e.data ||
                        out_word.out_of_range !== e.out_of_range) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected kind %0d data %0d flag %0d, %s %0d %0d %0d",
                                     e.kind, e.data, e.out_of_range, "got",
                                     out_word.kind, out_word.data, out_word.out_of_range);
                    end
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
        end
    end

    // Run timeout.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver stall while words keep coming, so the block backs up.
    initial begin
        recv_hold = 1'b0;
        wait (phase_num == 2);
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_word(input t_cmd c, input int r, input int k,
                                       input logic [31:0] v);
        t_in w;
        w.command = c;
        w.row = r[3:0];
        w.col = k[3:0];
        w.value = v;
        if (c == CMD_WR_A) left_set[r][k] = 1'b1;
        if (c == CMD_WR_B) right_set[r][k] = 1'b1;
        pending_words.push_back(w);
    endfunction

    // Load the next multiply's unwritten operands plus random rewrites, then start it.
    function automatic void queue_multiply();
        int rn;
        int kn;
        int cn;
        rn = capped(gen_rows);
        kn = capped(gen_inner);
        cn = capped(gen_cols);
        for (int i = 0; i < rn; i++)
            for (int k = 0; k < kn; k++)
                if (!left_set[i][k] || $urandom_range(7) == 0)
                    queue_word(CMD_WR_A, i, k, pick_value());
        for (int k = 0; k < kn; k++)
            for (int j = 0; j < cn; j++)
                if (!right_set[k][j] || $urandom_range(7) == 0)
                    queue_word(CMD_WR_B, k, j, pick_value());
        queue_word(CMD_MUL, $urandom_range(15), $urandom_range(15), $urandom);
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [4:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LEFT_ROWS:  rows_reg = v;
            CFG_INNER_SIZE: inner_reg = v;
            default:        cols_reg = v;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Stimulus: a directed opening, then randomized phases over several sizes.
    initial begin
        logic [4:0] sizes[NUM_PHASES][3];
        int mul_cap;
        int muls;
        sizes = '{'{5'd2, 5'd3, 5'd2}, '{5'd1, 5'd1, 5'd1}, '{5'd4, 5'd2, 5'd3},
                  '{5'd0, 5'd5, 5'd3}, '{5'd4, 5'd0, 5'd4}, '{5'd3, 5'd16, 5'd2},
                  '{5'd31, 5'd2, 5'd31}, '{5'd5, 5'd7, 5'd6}, '{5'd16, 5'd8, 5'd16},
                  '{5'd8, 5'd4, 5'd8}, '{5'd6, 5'd31, 5'd1}, '{5'd3, 5'd3, 5'd0}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        phase_num = -1;
        send_idle = 20;
        recv_idle = 79;
        mismatches = 0;
        results_seen = 0;
        words_sent = 0;
        multiplies_seen = 0;
        cycle_count = 0;
        rows_reg = CFG_RESET;
        inner_reg = CFG_RESET;
        cols_reg = CFG_RESET;
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++) begin
                left_mat[i][j] = '0;
                right_mat[i][j] = '0;
                product_mat[i][j] = '0;
                left_set[i][j] = 1'b0;
                right_set[i][j] = 1'b0;
            end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads of the cleared product at reset size, then a small multiply.
        gen_rows = CFG_RESET;
        gen_inner = CFG_RESET;
        gen_cols = CFG_RESET;
        queue_word(CMD_RD_C, 0, 0, 32'h0);
        queue_word(CMD_RD_C, 15, 15, 32'hffff_ffff);
        queue_word(CMD_WR_A, 15, 15, 32'h8000_0000);
        queue_word(CMD_WR_B, 15, 0, 32'h7fff_ffff);
        wait_drained();
        write_register(CFG_LEFT_ROWS, 5'd2);
        write_register(CFG_INNER_SIZE, 5'd2);
        write_register(CFG_RIGHT_COLS, 5'd2);
        gen_rows = 5'd2;
        gen_inner = 5'd2;
        gen_cols = 5'd2;
        queue_word(CMD_WR_A, 0, 0, 32'h8000_0000);
        queue_word(CMD_WR_A, 0, 1, 32'h7fff_ffff);
        queue_word(CMD_WR_A, 1, 0, 32'hffff_ffff);
        queue_word(CMD_WR_A, 1, 1, 32'h0);
        queue_word(CMD_WR_B, 0, 0, 32'h8000_0000);
        queue_word(CMD_WR_B, 0, 1, 32'hffff_ffff);
        queue_word(CMD_WR_B, 1, 0, 32'h7fff_ffff);
        queue_word(CMD_WR_B, 1, 1, 32'h7fff_ffff);
        queue_word(CMD_MUL, 0, 0, 32'h0);
        queue_word(CMD_RD_C, 0, 0, 32'h0);
        queue_word(CMD_RD_C, 0, 1, 32'h0);
        queue_word(CMD_RD_C, 1, 0, 32'h0);
        queue_word(CMD_RD_C, 1, 1, 32'h0);
        queue_word(CMD_RD_C, 2, 0, 32'h0);
        queue_word(CMD_RD_C, 0, 2, 32'h0);
        queue_word(CMD_RD_C, 15, 15, 32'h0);
        wait_drained();

        // Random phases: operand loads, multiplies and reads, with some noise.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PHASES / 3) begin
                send_idle = 20;
                recv_idle = 79;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle = 79;
                recv_idle = 20;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_register(CFG_LEFT_ROWS, sizes[p][0]);
            write_register(CFG_INNER_SIZE, sizes[p][1]);
            write_register(CFG_RIGHT_COLS, sizes[p][2]);
            gen_rows = sizes[p][0];
            gen_inner = sizes[p][1];
            gen_cols = sizes[p][2];
            phase_num = p;
            mul_cap = (capped(gen_rows) * capped(gen_cols) * capped(gen_inner) > 1000)
                      ? 2 : 8;
            muls = 0;
            for (int n = 0; n < 40; n++) begin
                case ($urandom_range(9))
                    0: begin
                        if (muls < mul_cap) begin
                            queue_multiply();
                            muls++;
                        end else begin
                            queue_word(CMD_RD_C, $urandom_range(15), $urandom_range(15),
                                       $urandom);
                        end
                    end
                    1: queue_word(CMD_WR_A, $urandom_range(15), $urandom_range(15),
                                  pick_value());
                    2: queue_word(CMD_WR_B, $urandom_range(15), $urandom_range(15),
                                  pick_value());
                    3, 4: queue_word(CMD_RD_C, $urandom_range(15), $urandom_range(15),
                                     $urandom);
                    default: queue_word(CMD_RD_C,
                                        $urandom_range(capped(gen_rows) > 0 ?
                                                       capped(gen_rows) - 1 : 0),
                                        $urandom_range(capped(gen_cols) > 0 ?
                                                       capped(gen_cols) - 1 : 0),
                                        $urandom);
                endcase
            end
            wait_drained();
        end

        if (expected_results.size() != 0) mismatches++;
        $display("Covered %0d input words, %0d results, %0d multiplies over %0d sizes,",
                 words_sent, results_seen, multiplies_seen, NUM_PHASES + 2);
        $display("with sender and receiver stalls and one long output back-up.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
